@@ rtl/core/bpcw_pkg.sv @@
// package with beat types, register indexes and crc/whitening functions
`timescale 1ns / 1ps

package bpcw_pkg;

  localparam int unsigned CRC_W   = 24;
  localparam int unsigned LFSR_W  = 7;
  localparam int unsigned CHAN_W  = 6;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [CRC_W-1:0]  CRC_POLY       = 24'h00065B;
  localparam logic [CRC_W-1:0]  CRC_SEED_RESET = 24'h555555;
  localparam logic [CHAN_W-1:0] CHANNEL_RESET  = 6'd37;

  typedef enum logic [0:0] {
    CFG_CHANNEL  = 1'b0,
    CFG_CRC_SEED = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pdu_byte;
    logic              last;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_crc;
    logic              end_of_packet;
  } out_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LFSR_W-1:0] lfsr;
  } whiten_res_t;

  typedef struct packed {
    logic              valid;
    in_beat_t          beat;
  } in_slot_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

  // channel bit 0 lands in lfsr bit 6, bit 0 always set
  function automatic logic [LFSR_W-1:0] lfsr_seed(input logic [CHAN_W-1:0] ch);
    return {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b1};
  endfunction

  // lsb first, feedback when crc msb differs from data bit
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[CRC_W-1] ^ d[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // x^7 + x^4 + 1 whitening, one lfsr step per data bit
  function automatic whiten_res_t whiten_byte(input logic [BYTE_W-1:0] d,
                                              input logic [LFSR_W-1:0] lfsr);
    whiten_res_t res;
    logic [LFSR_W-1:0] l;
    logic [BYTE_W-1:0] o;
    logic              top;
    l = lfsr;
    o = d;
    for (int i = 0; i < BYTE_W; i++) begin
      top  = l[LFSR_W-1];
      o[i] = d[i] ^ top;
      l    = {l[5:4], l[3] ^ top, l[2:0], top};
    end
    res.data = o;
    res.lfsr = l;
    return res;
  endfunction

endpackage

@@ rtl/core/bpcw_cfg_regs.sv @@
// configuration registers: rf channel and crc seed
`timescale 1ns / 1ps

module bpcw_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  bpcw_pkg::cfg_idx_t                wr_index,
  input  logic [bpcw_pkg::CRC_W-1:0]        wr_data,
  output logic [bpcw_pkg::CHAN_W-1:0]       channel,
  output logic [bpcw_pkg::CRC_W-1:0]        crc_seed
);

  logic [bpcw_pkg::CHAN_W-1:0] channel_r;
  logic [bpcw_pkg::CRC_W-1:0]  crc_seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r  <= bpcw_pkg::CHANNEL_RESET;
      crc_seed_r <= bpcw_pkg::CRC_SEED_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bpcw_pkg::CFG_CHANNEL:  channel_r  <= wr_data[bpcw_pkg::CHAN_W-1:0];
        bpcw_pkg::CFG_CRC_SEED: crc_seed_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign channel  = channel_r;
  assign crc_seed = crc_seed_r;

endmodule

@@ rtl/core/bpcw_in_stage.sv @@
// input register holding one pdu beat until the engine consumes it
`timescale 1ns / 1ps

module bpcw_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpcw_pkg::in_beat_t  in_data,
  input  logic                consume,
  output bpcw_pkg::in_slot_t  slot
);

  logic               valid_r;
  bpcw_pkg::in_beat_t beat_r;

  assign in_ready = !valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_data;
    end
  end

  assign slot.valid = valid_r;
  assign slot.beat  = beat_r;

endmodule

@@ rtl/core/bpcw_engine.sv @@
// crc update, whitening and crc tail sequencing with the output register
`timescale 1ns / 1ps

module bpcw_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpcw_pkg::in_slot_t             slot,
  output logic                           consume,
  input  logic [bpcw_pkg::CHAN_W-1:0]    channel,
  input  logic [bpcw_pkg::CRC_W-1:0]     crc_seed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpcw_pkg::out_beat_t            out_data
);

  typedef enum logic [1:0] {
    PH_PDU,
    PH_CRC_HI,
    PH_CRC_MID,
    PH_CRC_LO
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic                          in_pkt_r, in_pkt_nxt;
  logic [bpcw_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic [bpcw_pkg::LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bpcw_pkg::out_beat_t           out_data_r, out_data_nxt;

  logic                          advance;
  logic                          work;
  logic [bpcw_pkg::CRC_W-1:0]    crc_cur;
  logic [bpcw_pkg::LFSR_W-1:0]   lfsr_cur;
  logic [bpcw_pkg::BYTE_W-1:0]   crc_sel;
  logic [bpcw_pkg::BYTE_W-1:0]   raw_byte;
  bpcw_pkg::whiten_res_t         wres;

  assign advance = !out_valid_r || out_ready;
  assign work    = slot.valid && advance;

  // packet start takes fresh seeds
  assign crc_cur  = in_pkt_r ? crc_r : crc_seed;
  assign lfsr_cur = (phase_r == PH_PDU && !in_pkt_r) ? bpcw_pkg::lfsr_seed(channel) : lfsr_r;

  always_comb begin
    case (phase_r)
      PH_CRC_HI:  crc_sel = crc_r[23:16];
      PH_CRC_MID: crc_sel = crc_r[15:8];
      PH_CRC_LO:  crc_sel = crc_r[7:0];
      default:    crc_sel = crc_r[7:0];
    endcase
  end

  assign raw_byte = (phase_r == PH_PDU) ? slot.beat.pdu_byte : bpcw_pkg::rev8(crc_sel);
  assign wres     = bpcw_pkg::whiten_byte(raw_byte, lfsr_cur);

  always_comb begin
    phase_nxt     = phase_r;
    in_pkt_nxt    = in_pkt_r;
    crc_nxt       = crc_r;
    lfsr_nxt      = lfsr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    consume       = 1'b0;
    if (work) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.out_byte        = wres.data;
      out_data_nxt.is_crc          = (phase_r != PH_PDU);
      out_data_nxt.end_of_packet   = (phase_r == PH_CRC_LO);
      lfsr_nxt                     = wres.lfsr;
      case (phase_r)
        PH_PDU: begin
          crc_nxt = bpcw_pkg::crc_byte(crc_cur, slot.beat.pdu_byte);
          if (slot.beat.last) begin
            phase_nxt = PH_CRC_HI;
          end else begin
            in_pkt_nxt = 1'b1;
            consume    = 1'b1;
          end
        end
        PH_CRC_HI:  phase_nxt = PH_CRC_MID;
        PH_CRC_MID: phase_nxt = PH_CRC_LO;
        PH_CRC_LO: begin
          phase_nxt  = PH_PDU;
          in_pkt_nxt = 1'b0;
          consume    = 1'b1;
        end
        default: phase_nxt = PH_PDU;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PDU;
      in_pkt_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      in_pkt_r    <= in_pkt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    crc_r      <= crc_nxt;
    lfsr_r     <= lfsr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/ble_pdu_crc_and_whitening.sv @@
// top level: ble pdu crc-24 and data whitening byte stream
//
// in_*: one raw pdu byte per beat, header first, last marks the final pdu byte.
// out_*: whitened pdu bytes; after a last byte the three crc bytes follow,
//   high byte first, each bit-reversed and whitened, is_crc set on all
//   three and end_of_packet on the third.
// cfg_*: writes channel (index 0) or crc_seed (index 1); cfg_ready is always
//   high. new values apply from the next packet start.
// an accepted byte goes from the input register into the output register once
//   the output register can take it. throughput: one byte per cycle while
//   out_ready is high; a last byte holds the input register while its pdu byte
//   and three crc bytes leave, one per cycle, through the single output register.
// the eight crc and lfsr bit steps are unrolled between the input register
//   and the output register.
// reset: channel 37, crc seed 0x555555, both registers empty, no packet open.
// receiver stall: the output register holds its beat, the input register
//   fills and in_ready drops; nothing is lost.
`timescale 1ns / 1ps

module ble_pdu_crc_and_whitening (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpcw_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpcw_pkg::out_beat_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  bpcw_pkg::cfg_idx_t             cfg_index,
  input  logic [bpcw_pkg::CRC_W-1:0]     cfg_data
);

  logic [bpcw_pkg::CHAN_W-1:0] channel;
  logic [bpcw_pkg::CRC_W-1:0]  crc_seed;
  bpcw_pkg::in_slot_t          slot;
  logic                        consume;

  assign cfg_ready = 1'b1;

  bpcw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .channel  (channel),
    .crc_seed (crc_seed)
  );

  bpcw_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .consume  (consume),
    .slot     (slot)
  );

  bpcw_engine u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .slot      (slot),
    .consume   (consume),
    .channel   (channel),
    .crc_seed  (crc_seed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // end of packet only on a crc byte
  a_eop_is_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.end_of_packet || out_data.is_crc))
    else $error("end_of_packet on a non-crc beat");

  // crc bytes leave back to back
  a_crc_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.is_crc && !out_data.end_of_packet)
      |=> (out_valid && out_data.is_crc))
    else $error("gap inside crc tail");

  // no crc byte right after the end of a packet
  a_eop_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.end_of_packet)
      |=> !(out_valid && out_data.is_crc))
    else $error("crc beat after end of packet");

endmodule
